// ===== sv/oaht_pkg.sv =====
package oaht_pkg;

	localparam int KEY_BITS        = 32;
	localparam int VALUE_BITS      = 32;
	localparam int LIVE_BITS       = 11;
	localparam int CFG_BITS        = 4;
	localparam int TABLE_SLOTS_DEF = 1024;
	localparam int MIN_LOG2        = 3;
	localparam int PERTURB_SHIFT   = 5;
	localparam int PROBE_EXTRA     = 16;

	localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd10;

	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [1:0] {
		SLOT_EMPTY,
		SLOT_LIVE,
		SLOT_DEL
	} slot_st_t;

	typedef struct packed {
		slot_st_t               st;
		logic [KEY_BITS-1:0]    key;
		logic [VALUE_BITS-1:0]  value;
	} slot_t;

	typedef struct packed {
		logic [1:0]             opcode;
		logic [KEY_BITS-1:0]    key;
		logic [VALUE_BITS-1:0]  new_value;
	} cmd_t;

	typedef struct packed {
		logic                   found;
		logic [VALUE_BITS-1:0]  prior_value;
		logic                   status;
		logic [LIVE_BITS-1:0]   live_count;
		logic                   load_high;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE
	} seq_state_t;

	function automatic logic [KEY_BITS-1:0] key_hash(input logic [KEY_BITS-1:0] k);
		if (k == '0 || k == '1) begin
			return {{(KEY_BITS-1){1'b1}}, 1'b0};
		end
		return k;
	endfunction

endpackage

// ===== sv/oaht_ram.sv =====
module oaht_ram #(
	parameter int DEPTH  = oaht_pkg::TABLE_SLOTS_DEF,
	parameter int DATA_W = $bits(oaht_pkg::slot_t)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/oaht_seq.sv =====
module oaht_seq #(
	parameter int TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  oaht_pkg::cmd_t                      cmd,
	input  logic [$clog2(TABLE_SLOTS)-1:0]      mask,
	output logic                                done,
	output oaht_pkg::rsp_t                      rsp,
	output logic [$clog2(TABLE_SLOTS)-1:0]      rd_addr,
	input  logic [$bits(oaht_pkg::slot_t)-1:0]  rd_data,
	output logic                                wr_en,
	output logic [$clog2(TABLE_SLOTS)-1:0]      wr_addr,
	output logic [$bits(oaht_pkg::slot_t)-1:0]  wr_data
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int LD_W  = CNT_W + 2;
	localparam int N_W   = $clog2(TABLE_SLOTS + oaht_pkg::PROBE_EXTRA + 1);

	oaht_pkg::seq_state_t state_q, state_d;

	logic [IDX_W-1:0]               clr_addr_q;
	logic [1:0]                     op_q;
	logic [oaht_pkg::KEY_BITS-1:0]  key_q;
	logic [oaht_pkg::VALUE_BITS-1:0] val_q;
	logic [IDX_W-1:0]               ix_q;
	logic [oaht_pkg::KEY_BITS-1:0]  perturb_q;
	logic [N_W-1:0]                 n_q;
	logic                           have_tomb_q;
	logic [IDX_W-1:0]               tomb_slot_q;
	logic [CNT_W-1:0]               used_q, used_d;
	logic [CNT_W-1:0]               tomb_cnt_q, tomb_d;
	logic                           done_q;
	oaht_pkg::rsp_t                 rsp_q;

	oaht_pkg::slot_t                rd_slot, wr_slot;
	logic [oaht_pkg::KEY_BITS-1:0]  hash_in, perturb_n;
	logic [IDX_W-1:0]               cur, ix_n, tomb_at;
	logic                           match, empty, deleted, exhausted, term, tomb_now;
	logic                           accept, fin, found_d, status_d;
	logic [CNT_W-1:0]               live_d;

	assign rd_slot   = oaht_pkg::slot_t'(rd_data);
	assign hash_in   = oaht_pkg::key_hash(cmd.key);
	assign cur       = ix_q & mask;
	assign match     = (rd_slot.st == oaht_pkg::SLOT_LIVE) && (rd_slot.key == key_q);
	assign empty     = rd_slot.st == oaht_pkg::SLOT_EMPTY;
	assign deleted   = rd_slot.st == oaht_pkg::SLOT_DEL;
	assign exhausted = n_q == (N_W'(mask) + N_W'(oaht_pkg::PROBE_EXTRA));
	assign term      = match | empty | exhausted;
	assign tomb_now  = have_tomb_q | deleted;
	assign tomb_at   = have_tomb_q ? tomb_slot_q : cur;
	assign perturb_n = perturb_q >> oaht_pkg::PERTURB_SHIFT;
	assign ix_n      = IDX_W'(1) + (ix_q << 2) + ix_q + perturb_n[IDX_W-1:0];

	// sequencer: clear sweep, idle, one probe per cycle
	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		fin      = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = cur;
		wr_slot  = '{st: oaht_pkg::SLOT_LIVE, key: key_q, value: val_q};
		rd_addr  = ix_n & mask;
		used_d   = used_q;
		tomb_d   = tomb_cnt_q;
		found_d  = 1'b0;
		status_d = oaht_pkg::STATUS_DONE;
		unique case (state_q)
			oaht_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_slot = '{st: oaht_pkg::SLOT_EMPTY, key: '0, value: '0};
				if (clr_addr_q == IDX_W'(TABLE_SLOTS - 1)) begin
					state_d = oaht_pkg::ST_IDLE;
				end
			end
			oaht_pkg::ST_IDLE: begin
				rd_addr = hash_in[IDX_W-1:0] & mask;
				if (start) begin
					accept  = 1'b1;
					state_d = oaht_pkg::ST_PROBE;
				end
			end
			oaht_pkg::ST_PROBE: begin
				if (term) begin
					fin     = 1'b1;
					found_d = match;
					state_d = oaht_pkg::ST_IDLE;
					if (op_q == oaht_pkg::OP_INSERT) begin
						priority if (match) begin
							wr_en = 1'b1;
						end else if (tomb_now) begin
							wr_en   = 1'b1;
							wr_addr = tomb_at;
							if (tomb_cnt_q != '0) begin
								tomb_d = tomb_cnt_q - CNT_W'(1);
							end
						end else if (empty && used_q < CNT_W'(mask)) begin
							wr_en  = 1'b1;
							used_d = used_q + CNT_W'(1);
						end else begin
							status_d = oaht_pkg::STATUS_FULL;
						end
					end else if (op_q == oaht_pkg::OP_DELETE && match) begin
						wr_en      = 1'b1;
						wr_slot.st = oaht_pkg::SLOT_DEL;
						tomb_d     = tomb_cnt_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = oaht_pkg::ST_IDLE;
			end
		endcase
	end

	assign wr_data = wr_slot;
	assign live_d  = used_d - tomb_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaht_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			n_q         <= '0;
			have_tomb_q <= 1'b0;
			used_q      <= '0;
			tomb_cnt_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= fin;
			if (state_q == oaht_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			end
			if (accept) begin
				n_q         <= '0;
				have_tomb_q <= 1'b0;
			end else if (state_q == oaht_pkg::ST_PROBE && !term) begin
				n_q <= n_q + N_W'(1);
				if (deleted) begin
					have_tomb_q <= 1'b1;
				end
			end
			if (fin) begin
				used_q     <= used_d;
				tomb_cnt_q <= tomb_d;
			end
		end
	end

	// transaction payload and probe walk
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= cmd.opcode;
			key_q     <= cmd.key;
			val_q     <= cmd.new_value;
			ix_q      <= hash_in[IDX_W-1:0];
			perturb_q <= hash_in;
		end else if (state_q == oaht_pkg::ST_PROBE && !term) begin
			ix_q      <= ix_n;
			perturb_q <= perturb_n;
			if (deleted && !have_tomb_q) begin
				tomb_slot_q <= cur;
			end
		end
		if (fin) begin
			rsp_q.found       <= found_d;
			rsp_q.prior_value <= match ? rd_slot.value : '0;
			rsp_q.status      <= status_d;
			rsp_q.live_count  <= oaht_pkg::LIVE_BITS'(live_d);
			rsp_q.load_high   <= (LD_W'(used_d) + LD_W'({used_d, 1'b0}))
				>= LD_W'({mask, 1'b0});
		end
	end

	assign busy = state_q != oaht_pkg::ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_done_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == oaht_pkg::ST_PROBE))
		else $error("result strobe without a finished probe");

	a_tomb_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		tomb_cnt_q <= used_q)
		else $error("tombstone count exceeds used slots");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status == oaht_pkg::STATUS_FULL) |-> !rsp_q.found)
		else $error("refused insert reports a hit");

	a_start_probes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oaht_pkg::ST_IDLE && start) |=> (state_q == oaht_pkg::ST_PROBE))
		else $error("accepted transaction did not start probing");

	a_counts_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != oaht_pkg::ST_PROBE) |=> ($stable(used_q) && $stable(tomb_cnt_q)))
		else $error("slot counters changed outside a probe");
`endif

endmodule

// ===== sv/open_address_hash_table.sv =====
// result: done is registered from the end of the probe walk, P = probes walked
// (one probe per cycle, 1 .. mask+17); the probe loop over the slot memory sets P
// flow: start is taken only when idle; busy drops in the cycle the result shows
// reset: asynchronous, active low; a sweep over all TABLE_SLOTS slots then marks them
// empty with busy high; table_log2 may be written during the sweep
// results cannot be stalled and are valid for the single cycle done is high
module open_address_hash_table #(
	parameter int TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  oaht_pkg::cmd_t                  cmd,
	output logic                            done,
	output oaht_pkg::rsp_t                  rsp,
	input  logic                            cfg_wr_en,
	input  logic [oaht_pkg::CFG_BITS-1:0]   cfg_wr_data
);

	localparam int IDX_W  = $clog2(TABLE_SLOTS);
	localparam int SLOT_W = $bits(oaht_pkg::slot_t);
	localparam int LG_W   = oaht_pkg::CFG_BITS + 1;

	logic [oaht_pkg::CFG_BITS-1:0] cfg_q;
	logic [LG_W-1:0]               lg;
	logic [IDX_W-1:0]              mask;
	logic [IDX_W-1:0]              rd_addr, wr_addr;
	logic [SLOT_W-1:0]             rd_data, wr_data;
	logic                          wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= oaht_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	// saturate table size into the legal range
	always_comb begin
		priority if (LG_W'(cfg_q) < LG_W'(oaht_pkg::MIN_LOG2)) begin
			lg = LG_W'(oaht_pkg::MIN_LOG2);
		end else if (LG_W'(cfg_q) > LG_W'(IDX_W)) begin
			lg = LG_W'(IDX_W);
		end else begin
			lg = LG_W'(cfg_q);
		end
	end

	assign mask = ~({IDX_W{1'b1}} << lg);

	oaht_seq #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.mask    (mask),
		.done    (done),
		.rsp     (rsp),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	oaht_ram #(
		.DEPTH  (TABLE_SLOTS),
		.DATA_W (SLOT_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

// ===== sim/hash_table_checker.sv =====
`timescale 1ns / 100ps

module hash_table_checker
	import oaht_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  cmd_t                cmd,
	input  logic                done,
	input  rsp_t                rsp,
	input  logic                cfg_wr_en,
	input  logic [CFG_BITS-1:0] cfg_wr_data,
	output int                  errors,
	output int                  pending,
	output int                  hits,
	output int                  refusals
);

	localparam int MAX_LOG2  = $clog2(TABLE_SLOTS);

	slot_st_t              slot_state [TABLE_SLOTS];
	logic [KEY_BITS-1:0]   slot_key   [TABLE_SLOTS];
	logic [VALUE_BITS-1:0] slot_value [TABLE_SLOTS];
	int unsigned           used_cnt;
	int unsigned           tomb_cnt;
	logic [CFG_BITS-1:0]   log2_reg;
	rsp_t                  rsp_due [$];
	rsp_t                  want;

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, exp_val);
		errors++;
	endtask

	// applies one transaction to the shadow table and returns its result
	function automatic rsp_t table_access(input cmd_t c);
		logic [KEY_BITS-1:0] h;
		logic [KEY_BITS-1:0] perturb;
		logic [KEY_BITS-1:0] ix;
		int unsigned lg, mask, probe, s, hit, empty_ix, tomb_ix;
		bit hit_ok, empty_ok, tomb_ok, stop;
		rsp_t r;
		lg = log2_reg;
		if (lg < MIN_LOG2) begin
			lg = MIN_LOG2;
		end
		if (lg > MAX_LOG2) begin
			lg = MAX_LOG2;
		end
		mask = (1 << lg) - 1;
		h = c.key;
		if (h == '0 || h == '1) begin
			h = {{(KEY_BITS-1){1'b1}}, 1'b0};
		end
		perturb = h;
		ix = h;
		hit_ok = 0;
		empty_ok = 0;
		tomb_ok = 0;
		stop = 0;
		hit = 0;
		empty_ix = 0;
		tomb_ix = 0;
		probe = 0;
		while (probe < mask + PROBE_EXTRA + 1 && !stop) begin
			s = ix & mask;
			if (slot_state[s] == SLOT_LIVE && slot_key[s] == c.key) begin
				hit_ok = 1;
				hit = s;
				stop = 1;
			end else if (slot_state[s] == SLOT_EMPTY) begin
				empty_ok = 1;
				empty_ix = s;
				stop = 1;
			end else begin
				if (slot_state[s] == SLOT_DEL && !tomb_ok) begin
					tomb_ok = 1;
					tomb_ix = s;
				end
				perturb = perturb >> PERTURB_SHIFT;
				ix = 1 + 5 * ix + perturb;
				probe++;
			end
		end
		r = '0;
		r.status = STATUS_DONE;
		r.found = hit_ok;
		if (hit_ok) begin
			r.prior_value = slot_value[hit];
		end
		if (c.opcode == OP_INSERT) begin
			if (hit_ok) begin
				slot_value[hit] = c.new_value;
			end else if (tomb_ok) begin
				slot_state[tomb_ix] = SLOT_LIVE;
				slot_key[tomb_ix] = c.key;
				slot_value[tomb_ix] = c.new_value;
				if (tomb_cnt > 0) begin
					tomb_cnt--;
				end
			end else if (empty_ok && used_cnt + 1 < mask + 1) begin
				slot_state[empty_ix] = SLOT_LIVE;
				slot_key[empty_ix] = c.key;
				slot_value[empty_ix] = c.new_value;
				used_cnt++;
			end else begin
				r.status = STATUS_FULL;
			end
		end else if (c.opcode == OP_DELETE && hit_ok) begin
			slot_state[hit] = SLOT_DEL;
			tomb_cnt++;
		end
		r.live_count = LIVE_BITS'(used_cnt - tomb_cnt);
		r.load_high = (3 * used_cnt >= 2 * mask);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				slot_state[i] = SLOT_EMPTY;
			end
			used_cnt = 0;
			tomb_cnt = 0;
			log2_reg = CFG_RESET;
			rsp_due.delete();
			errors = 0;
			hits = 0;
			refusals = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					note_mismatch("result with no transaction pending", 1, 0);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.found !== want.found) begin
						note_mismatch("found", rsp.found, want.found);
					end
					if (rsp.prior_value !== want.prior_value) begin
						note_mismatch("prior_value", rsp.prior_value, want.prior_value);
					end
					if (rsp.status !== want.status) begin
						note_mismatch("status", rsp.status, want.status);
					end
					if (rsp.live_count !== want.live_count) begin
						note_mismatch("live_count", rsp.live_count, want.live_count);
					end
					if (rsp.load_high !== want.load_high) begin
						note_mismatch("load_high", rsp.load_high, want.load_high);
					end
					hits += want.found;
					refusals += (want.status == STATUS_FULL);
				end
			end
			if (start && !busy) begin
				rsp_due.push_back(table_access(cmd));
			end
			if (cfg_wr_en) begin
				log2_reg = cfg_wr_data;
			end
			pending <= rsp_due.size();
		end
	end

endmodule

// ===== sim/open_address_hash_table_test.sv =====
`timescale 1ns / 100ps

module open_address_hash_table_test;
	import oaht_pkg::*;

	localparam logic [1:0] OP_LOOKUP     = 2'd0;
	localparam logic [1:0] OP_LOOKUP_ALT = 2'd3;
	localparam int IDLE_LIMIT    = 8000;
	localparam int SETTLE_CYCLES = TABLE_SLOTS_DEF + PROBE_EXTRA + 8;
	localparam int PHASE_ITEMS   = 67;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	cmd_t                cmd;
	logic                done;
	rsp_t                rsp;
	logic                cfg_wr_en;
	logic [CFG_BITS-1:0] cfg_wr_data;

	int errors, pending, hits, refusals;
	int idle_cycles = 0;
	int sent = 0;
	bit eager = 0;
	logic [KEY_BITS-1:0] known_keys [$];
	logic [KEY_BITS-1:0] key_pool [$];
	logic [CFG_BITS-1:0] sizes [9] = '{4'd10, 4'd5, 4'd0, 4'd15, 4'd7, 4'd12, 4'd4, 4'd10, 4'd9};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	open_address_hash_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	hash_table_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.errors      (errors),
		.pending     (pending),
		.hits        (hits),
		.refusals    (refusals)
	);

	// cycles with no transaction in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic issue(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		int gap;
		gap = eager ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= '{opcode: op, key: k, new_value: v};
		do @(posedge clk); while (busy);
		sent++;
		if (op == OP_INSERT) begin
			known_keys.push_back(k);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_size(input logic [CFG_BITS-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int r;
		logic [1:0] op;
		logic [KEY_BITS-1:0] k;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = CFG_RESET;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		set_size(4'd3);

		// remapped keys sharing one hash, update, delete, tombstone reuse, full table
		issue(OP_LOOKUP, '0, $urandom);
		issue(OP_INSERT, '0, '1);
		issue(OP_INSERT, '1, '0);
		issue(OP_INSERT, 32'hFFFF_FFFE, 32'hA5A5_A5A5);
		issue(OP_LOOKUP, '1, '0);
		issue(OP_LOOKUP_ALT, '0, '1);
		issue(OP_INSERT, '0, 32'h1234_5678);
		issue(OP_DELETE, '1, '0);
		issue(OP_DELETE, '1, '0);
		issue(OP_INSERT, '1, 32'h5A5A_5A5A);
		for (int i = 1; i <= 5; i++) begin
			issue(OP_INSERT, i * 8, $urandom);
		end
		drain();

		// grow the table, fill the low slots, then shrink: probes run out
		set_size(4'd4);
		for (int i = 0; i < 8; i++) begin
			issue(OP_INSERT, 32'h100 + i, $urandom);
		end
		drain();
		set_size(4'd3);
		issue(OP_LOOKUP, 32'h0BAD_0000, '0);
		issue(OP_INSERT, 32'h0BAD_0000, 32'h0000_0001);
		issue(OP_DELETE, 32'hFFFF_FFFE, '0);
		issue(OP_INSERT, 32'h0BAD_0000, 32'h8000_0000);
		drain();

		foreach (sizes[p]) begin
			set_size(sizes[p]);
			eager = ($urandom_range(0, 3) == 0);
			key_pool.delete();
			repeat ($urandom_range(6, 24)) begin
				r = $urandom_range(0, 7);
				if (r == 0) begin
					k = '0;
				end else if (r == 1) begin
					k = '1;
				end else if (r == 2) begin
					k = 32'hFFFF_FFFE;
				end else if (r < 5) begin
					k = ($urandom & ~32'h3FF) | $urandom_range(0, 7);
				end else begin
					k = $urandom;
				end
				key_pool.push_back(k);
			end
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(0, 19);
				if (r < 9) begin
					op = OP_INSERT;
				end else if (r < 15) begin
					op = OP_LOOKUP;
				end else if (r < 19) begin
					op = OP_DELETE;
				end else begin
					op = OP_LOOKUP_ALT;
				end
				r = $urandom_range(0, 9);
				if (r == 0) begin
					k = $urandom;
				end else if (r < 3) begin
					k = known_keys[$urandom_range(0, known_keys.size() - 1)];
				end else begin
					k = key_pool[$urandom_range(0, key_pool.size() - 1)];
				end
				issue(op, k, $urandom);
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("ran %0d transactions over %0d table size settings", sent, $size(sizes) + 3);
		$display("%0d transactions found their key, %0d inserts were refused", hits, refusals);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
